### sv/tcpr_pkg.sv
// Package for the text cell pixel renderer: cell geometry, field widths,
// register codes, palette and color packing functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcpr_pkg;

    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 16;
    localparam int CELL_PAD     = 1;
    localparam int CELL_W       = GLYPH_WIDTH + 2 * CELL_PAD;
    localparam int CELL_H       = GLYPH_HEIGHT + 2 * CELL_PAD;

    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int LINE_W     = 5;
    localparam int GLYPH_W    = GLYPH_WIDTH;
    localparam int ATTR_W     = 8;
    localparam int OFS_W      = 28;
    localparam int PIX_W      = 32;
    localparam int PB_W       = 3;
    localparam int SW_W       = 13;
    localparam int BPP_W      = 6;
    localparam int SIZE_W     = 4;
    localparam int POS_W      = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;
    localparam int LIDX_W     = $clog2((1 << ROW_W) * CELL_H);
    localparam int COL10_W    = $clog2((1 << COL_W) * CELL_W);
    localparam int COLPB_W    = COL10_W + 2;
    localparam int PROD_W     = LIDX_W + SW_W;
    localparam int X_W        = $clog2(CELL_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH   = 4'd0,
        REG_BITS_PER_PIXEL = 4'd1,
        REG_RED_SIZE       = 4'd2,
        REG_GREEN_SIZE     = 4'd3,
        REG_BLUE_SIZE      = 4'd4,
        REG_RED_POSITION   = 4'd5,
        REG_GREEN_POSITION = 4'd6,
        REG_BLUE_POSITION  = 4'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [SW_W-1:0]   screen_width;
        logic [BPP_W-1:0]  bits_per_pixel;
        logic [SIZE_W-1:0] red_size;
        logic [SIZE_W-1:0] green_size;
        logic [SIZE_W-1:0] blue_size;
        logic [POS_W-1:0]  red_position;
        logic [POS_W-1:0]  green_position;
        logic [POS_W-1:0]  blue_position;
    } t_cfg;

    typedef struct packed {
        logic [OFS_W-1:0]  base;
        logic [PIX_W-1:0]  fg;
        logic [PIX_W-1:0]  bg;
        logic [CELL_W-1:0] mask;
        logic [PB_W-1:0]   pb;
    } t_item;

    function automatic logic [23:0] palette(input logic [3:0] idx);
        logic [23:0] c;
        begin
            unique case (idx)
                4'h0: c = 24'h000000;
                4'h1: c = 24'h0000A8;
                4'h2: c = 24'h00A800;
                4'h3: c = 24'h00A8A8;
                4'h4: c = 24'hA80000;
                4'h5: c = 24'hA800A8;
                4'h6: c = 24'hA85700;
                4'h7: c = 24'hA8A8A8;
                4'h8: c = 24'h575757;
                4'h9: c = 24'h5757FF;
                4'hA: c = 24'h57FF57;
                4'hB: c = 24'h57FFFF;
                4'hC: c = 24'hFF5757;
                4'hD: c = 24'hFF57FF;
                4'hE: c = 24'hFFFF57;
                default: c = 24'hFFFFFF;
            endcase
            return c;
        end
    endfunction

    function automatic logic [PIX_W-1:0] place_channel(input logic [7:0] chan,
                                                       input logic [SIZE_W-1:0] size,
                                                       input logic [POS_W-1:0] pos);
        logic [SIZE_W-1:0] s;
        logic [7:0]        v;
        begin
            s = (size > SIZE_W'(8)) ? SIZE_W'(8) : size;
            v = chan >> (SIZE_W'(8) - s);
            return PIX_W'(v) << pos;
        end
    endfunction

    function automatic logic [PIX_W-1:0] pack_color(input logic [3:0] idx, input t_cfg cfg);
        logic [23:0] c;
        begin
            c = palette(idx);
            return place_channel(c[23:16], cfg.red_size, cfg.red_position)
                 | place_channel(c[15:8], cfg.green_size, cfg.green_position)
                 | place_channel(c[7:0], cfg.blue_size, cfg.blue_position);
        end
    endfunction

    function automatic logic [PB_W-1:0] depth_bytes(input logic [BPP_W-1:0] bpp);
        logic [PB_W-1:0] pb;
        begin
            case (bpp)
                BPP_W'(16): pb = PB_W'(2);
                BPP_W'(24): pb = PB_W'(3);
                BPP_W'(32): pb = PB_W'(4);
                default:    pb = '0;
            endcase
            return pb;
        end
    endfunction

    function automatic logic [PIX_W-1:0] keep_mask(input logic [PB_W-1:0] pb);
        logic [PIX_W-1:0] k;
        begin
            case (pb)
                PB_W'(2): k = PIX_W'(32'h0000FFFF);
                PB_W'(3): k = PIX_W'(32'h00FFFFFF);
                default:  k = '1;
            endcase
            return k;
        end
    endfunction

endpackage

`default_nettype wire

### sv/tcpr_front.sv
// Front pipeline of the text cell pixel renderer: decode, line stride multiply,
// color packing and base offset, four register stages.
// Depends on tcpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcpr_front
    import tcpr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [COL_W-1:0]     i_cell_column,
    input  wire logic [ROW_W-1:0]     i_cell_row,
    input  wire logic [LINE_W-1:0]    i_cell_line,
    input  wire logic [GLYPH_W-1:0]   i_glyph_row_bits,
    input  wire logic [ATTR_W-1:0]    i_color_attribute,
    input  wire t_cfg                 i_cfg,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_item                     o_item
);

    logic en1, en2, en3, en4;
    logic draw, glyph_line;
    logic [PB_W-1:0] n_pb;

    logic                r_v1;
    logic [LIDX_W-1:0]   r_lidx1;
    logic [COL10_W-1:0]  r_col10_1;
    logic [CELL_W-1:0]   r_mask1;
    logic [3:0]          r_fg_idx1;
    logic [3:0]          r_bg_idx1;
    logic [PB_W-1:0]     r_pb1;

    logic                r_v2;
    logic [PROD_W-1:0]   r_prod2;
    logic [COLPB_W-1:0]  r_colpb2;
    logic [PIX_W-1:0]    r_fg2;
    logic [PIX_W-1:0]    r_bg2;
    logic [CELL_W-1:0]   r_mask2;
    logic [PB_W-1:0]     r_pb2;

    logic                r_v3;
    logic [OFS_W-1:0]    r_ppb3;
    logic [COLPB_W-1:0]  r_colpb3;
    logic [PIX_W-1:0]    r_fg3;
    logic [PIX_W-1:0]    r_bg3;
    logic [CELL_W-1:0]   r_mask3;
    logic [PB_W-1:0]     r_pb3;

    logic                r_v4;
    t_item               r_item4;

    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v4;
    assign o_item  = r_item4;

    assign n_pb       = depth_bytes(i_cfg.bits_per_pixel);
    assign draw       = (n_pb != '0) && (i_cell_line < LINE_W'(CELL_H));
    assign glyph_line = (i_cell_line >= LINE_W'(CELL_PAD))
                     && (i_cell_line < LINE_W'(GLYPH_HEIGHT + CELL_PAD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid && draw;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_lidx1   <= LIDX_W'(i_cell_row) * LIDX_W'(CELL_H) + LIDX_W'(i_cell_line);
            r_col10_1 <= COL10_W'(i_cell_column) * COL10_W'(CELL_W);
            r_mask1   <= glyph_line ? (CELL_W'(i_glyph_row_bits) << CELL_PAD) : '0;
            r_fg_idx1 <= i_color_attribute[3:0];
            r_bg_idx1 <= i_color_attribute[7:4];
            r_pb1     <= n_pb;
        end
        if (en2) begin
            r_prod2  <= PROD_W'(r_lidx1) * PROD_W'(i_cfg.screen_width);
            r_colpb2 <= COLPB_W'(r_col10_1) * COLPB_W'(r_pb1);
            r_fg2    <= pack_color(r_fg_idx1, i_cfg) & keep_mask(r_pb1);
            r_bg2    <= pack_color(r_bg_idx1, i_cfg) & keep_mask(r_pb1);
            r_mask2  <= r_mask1;
            r_pb2    <= r_pb1;
        end
        if (en3) begin
            r_ppb3   <= OFS_W'(r_prod2) * OFS_W'(r_pb2);
            r_colpb3 <= r_colpb2;
            r_fg3    <= r_fg2;
            r_bg3    <= r_bg2;
            r_mask3  <= r_mask2;
            r_pb3    <= r_pb2;
        end
        if (en4) begin
            r_item4.base <= r_ppb3 + OFS_W'(r_colpb3);
            r_item4.fg   <= r_fg3;
            r_item4.bg   <= r_bg3;
            r_item4.mask <= r_mask3;
            r_item4.pb   <= r_pb3;
        end
    end

endmodule

`default_nettype wire

### sv/tcpr_serial.sv
// Pixel serializer of the text cell pixel renderer: expands one cell line
// into one pixel per cycle behind an output register, while the output is not stalled.
// Depends on tcpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcpr_serial
    import tcpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire t_item             i_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [OFS_W-1:0]       o_byte_offset,
    output logic [PIX_W-1:0]       o_pixel_value,
    output logic [PB_W-1:0]        o_pixel_bytes,
    output logic                   o_last_of_line
);

    logic out_load, emit, last;

    logic                r_busy;
    logic [X_W-1:0]      r_x;
    logic [OFS_W-1:0]    r_off;
    logic [PIX_W-1:0]    r_fg;
    logic [PIX_W-1:0]    r_bg;
    logic [CELL_W-1:0]   r_mask;
    logic [PB_W-1:0]     r_pb;

    logic                r_out_valid;
    logic [OFS_W-1:0]    r_out_off;
    logic [PIX_W-1:0]    r_out_pix;
    logic [PB_W-1:0]     r_out_pb;
    logic                r_out_last;

    assign out_load = !r_out_valid || i_out_ready;
    assign emit     = r_busy && out_load;
    assign last     = (r_x == X_W'(CELL_W - 1));
    assign o_ready  = !r_busy || (emit && last);

    assign o_out_valid    = r_out_valid;
    assign o_byte_offset  = r_out_off;
    assign o_pixel_value  = r_out_pix;
    assign o_pixel_bytes  = r_out_pb;
    assign o_last_of_line = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_x         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= r_busy;
            end
            if (o_ready) begin
                r_busy <= i_valid;
                r_x    <= '0;
            end else if (emit) begin
                r_x <= r_x + X_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_off  <= r_off;
            r_out_pix  <= r_mask[CELL_W-1] ? r_fg : r_bg;
            r_out_pb   <= r_pb;
            r_out_last <= last;
        end
        if (o_ready && i_valid) begin
            r_off  <= i_item.base;
            r_fg   <= i_item.fg;
            r_bg   <= i_item.bg;
            r_mask <= i_item.mask;
            r_pb   <= i_item.pb;
        end else if (emit) begin
            r_off  <= r_off + OFS_W'(r_pb);
            r_mask <= r_mask << 1;
        end
    end

`ifndef SYNTHESIS
    a_idle_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_x == '0))
        else $error("pixel counter not at start while idle");

    a_pixel_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_pb == PB_W'(2) || r_out_pb == PB_W'(3)
                         || r_out_pb == PB_W'(4)))
        else $error("pixel emitted with a non-drawing depth");

    a_offset_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && !r_out_last) |=>
        (r_out_valid && r_out_off == $past(r_out_off) + OFS_W'($past(r_out_pb))))
        else $error("next pixel of a line not one pixel further");
`endif

endmodule

`default_nettype wire

### sv/text_cell_pixel_renderer_core.sv
// Top level of the text cell pixel renderer: configuration registers,
// front pipeline and pixel serializer.
// Depends on tcpr_pkg, tcpr_front, tcpr_serial.
//
//   channel   direction  handshake                    payload
//   input     in         i_in_valid / o_in_ready      cell column, row, line, glyph, attribute
//   output    out        o_out_valid / i_out_ready    byte offset, pixel, bytes, last flag
//   config    in         i_cfg_wr_en                  i_cfg_index, i_cfg_wdata
//
// Each accepted cell line yields 10 pixels, one per cycle while the output is
// not stalled; the serializer sets that rate.
// The first pixel passes the 4 front stages, the first loaded at the accepting
// edge, then the serializer and its output register. Lines that do not draw
// leave in the front stages.
// Reset is synchronous; it clears only control state and sets the configuration registers to their defaults.
// A stall at the output holds every full stage; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module text_cell_pixel_renderer_core
    import tcpr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [COL_W-1:0]       i_cell_column,
    input  wire logic [ROW_W-1:0]       i_cell_row,
    input  wire logic [LINE_W-1:0]      i_cell_line,
    input  wire logic [GLYPH_W-1:0]     i_glyph_row_bits,
    input  wire logic [ATTR_W-1:0]      i_color_attribute,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [OFS_W-1:0]            o_byte_offset,
    output logic [PIX_W-1:0]            o_pixel_value,
    output logic [PB_W-1:0]             o_pixel_bytes,
    output logic                        o_last_of_line
);

    t_cfg  r_cfg;
    t_item item;
    logic  item_valid, item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width   <= SW_W'(640);
            r_cfg.bits_per_pixel <= BPP_W'(32);
            r_cfg.red_size       <= SIZE_W'(8);
            r_cfg.green_size     <= SIZE_W'(8);
            r_cfg.blue_size      <= SIZE_W'(8);
            r_cfg.red_position   <= POS_W'(16);
            r_cfg.green_position <= POS_W'(8);
            r_cfg.blue_position  <= POS_W'(0);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_SCREEN_WIDTH:   r_cfg.screen_width   <= i_cfg_wdata[SW_W-1:0];
                REG_BITS_PER_PIXEL: r_cfg.bits_per_pixel <= i_cfg_wdata[BPP_W-1:0];
                REG_RED_SIZE:       r_cfg.red_size       <= i_cfg_wdata[SIZE_W-1:0];
                REG_GREEN_SIZE:     r_cfg.green_size     <= i_cfg_wdata[SIZE_W-1:0];
                REG_BLUE_SIZE:      r_cfg.blue_size      <= i_cfg_wdata[SIZE_W-1:0];
                REG_RED_POSITION:   r_cfg.red_position   <= i_cfg_wdata[POS_W-1:0];
                REG_GREEN_POSITION: r_cfg.green_position <= i_cfg_wdata[POS_W-1:0];
                REG_BLUE_POSITION:  r_cfg.blue_position  <= i_cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    tcpr_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_in_valid),
        .o_ready           (o_in_ready),
        .i_cell_column     (i_cell_column),
        .i_cell_row        (i_cell_row),
        .i_cell_line       (i_cell_line),
        .i_glyph_row_bits  (i_glyph_row_bits),
        .i_color_attribute (i_color_attribute),
        .i_cfg             (r_cfg),
        .o_valid           (item_valid),
        .i_ready           (item_ready),
        .o_item            (item)
    );

    tcpr_serial u_serial (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (item_valid),
        .o_ready        (item_ready),
        .i_item         (item),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_byte_offset  (o_byte_offset),
        .o_pixel_value  (o_pixel_value),
        .o_pixel_bytes  (o_pixel_bytes),
        .o_last_of_line (o_last_of_line)
    );

endmodule

`default_nettype wire
